[src/uvts_pkg.sv]
// Package with shared types, widths and constants of the UV tray sterilize sequencer.
`default_nettype none

package uvts_pkg;

    localparam int STEP_W     = 4;
    localparam int POS_W      = 2;
    localparam int TICK_W     = 16;
    localparam int SB_MIN_W   = 6;
    localparam int HOUR_W     = 4;
    localparam int RUN_MIN_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STANDBY_HOURS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_MINUTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAY_TIMEOUT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MIN = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [HOUR_W-1:0]    RST_STANDBY_HOURS = 4'd10;
    localparam logic [RUN_MIN_W-1:0] RST_RUN_MINUTES   = 8'd120;
    localparam logic [TICK_W-1:0]    RST_TRAY_TIMEOUT  = 16'd600;
    localparam logic [TICK_W-1:0]    RST_TICKS_PER_MIN = 16'd600;

    localparam logic [SB_MIN_W-1:0]  MINUTES_PER_HOUR = 6'd60;

    // Tray position codes.
    localparam logic [POS_W-1:0] POS_THROW  = 2'd1;
    localparam logic [POS_W-1:0] POS_MAKING = 2'd2;

    // Sequence step codes.
    localparam logic [STEP_W-1:0] STEP_STANDBY_A = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DOWN_CMD  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DOWN_WAIT = 4'd2;
    localparam logic [STEP_W-1:0] STEP_RUN_A     = 4'd3;
    localparam logic [STEP_W-1:0] STEP_STANDBY_B = 4'd4;
    localparam logic [STEP_W-1:0] STEP_UP_CMD    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_UP_WAIT   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_RUN_B     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_HOME_CMD  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_HOME_WAIT = 4'd9;
    localparam logic [STEP_W-1:0] STEP_RESTART   = 4'd10;

    typedef struct packed {
        logic [HOUR_W-1:0]    standby_hours;
        logic [RUN_MIN_W-1:0] run_minutes;
        logic [TICK_W-1:0]    tray_timeout_ticks;
        logic [TICK_W-1:0]    ticks_per_minute;
    } cfg_t;

    typedef struct packed {
        logic             ice_making_on;
        logic             ice_init_active;
        logic             ice_cycle_busy;
        logic             other_process_active;
        logic             tank_present;
        logic             system_ok;
        logic             motor_up_busy;
        logic             motor_down_busy;
        logic [POS_W-1:0] tray_position;
        logic             tank_open_pause;
        logic             extract_pause;
    } req_t;

    typedef struct packed {
        logic              uv_on;
        logic              tray_down_pulse;
        logic              tray_up_pulse;
        logic [STEP_W-1:0] seq_step;
    } rsp_t;

endpackage

`default_nettype wire

[src/uvts_if.sv]
// Channel interfaces of the UV tray sterilize sequencer: request, result and configuration.
`default_nettype none

interface uvts_req_if;
    logic                      valid;
    logic                      ready;
    logic                      ice_making_on;
    logic                      ice_init_active;
    logic                      ice_cycle_busy;
    logic                      other_process_active;
    logic                      tank_present;
    logic                      system_ok;
    logic                      motor_up_busy;
    logic                      motor_down_busy;
    logic [uvts_pkg::POS_W-1:0] tray_position;
    logic                      tank_open_pause;
    logic                      extract_pause;

    modport source (
        output valid, ice_making_on, ice_init_active, ice_cycle_busy,
               other_process_active, tank_present, system_ok, motor_up_busy,
               motor_down_busy, tray_position, tank_open_pause, extract_pause,
        input  ready
    );
    modport sink (
        input  valid, ice_making_on, ice_init_active, ice_cycle_busy,
               other_process_active, tank_present, system_ok, motor_up_busy,
               motor_down_busy, tray_position, tank_open_pause, extract_pause,
        output ready
    );
endinterface

interface uvts_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        uv_on;
    logic                        tray_down_pulse;
    logic                        tray_up_pulse;
    logic [uvts_pkg::STEP_W-1:0] seq_step;

    modport source (
        output valid, uv_on, tray_down_pulse, tray_up_pulse, seq_step,
        input  ready
    );
    modport sink (
        input  valid, uv_on, tray_down_pulse, tray_up_pulse, seq_step,
        output ready
    );
endinterface

interface uvts_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [uvts_pkg::CFG_IDX_W-1:0]  index;
    logic [uvts_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/uvts_seq.sv]
// Sequence state and next-state logic of the UV tray sterilize sequencer.
`default_nettype none

module uvts_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  uvts_pkg::req_t req,
    input  uvts_pkg::cfg_t cfg,
    output uvts_pkg::rsp_t rsp
);
    import uvts_pkg::*;

    logic [STEP_W-1:0]    step_reg, step_next;
    logic [TICK_W-1:0]    move_timer_reg, move_timer_next;
    logic                 uv_active_reg, uv_active_next;
    logic [TICK_W-1:0]    sb_ticks_reg, sb_ticks_next;
    logic [SB_MIN_W-1:0]  sb_minutes_reg, sb_minutes_next;
    logic [HOUR_W-1:0]    sb_hours_reg, sb_hours_next;
    logic [TICK_W-1:0]    run_ticks_reg, run_ticks_next;
    logic [RUN_MIN_W-1:0] run_minutes_reg, run_minutes_next;

    // Standby count chain: ticks roll into minutes, minutes into hours.
    logic [TICK_W-1:0]    sb_t_inc;
    logic                 sb_t_wrap;
    logic [SB_MIN_W-1:0]  sb_m_inc;
    logic                 sb_m_wrap;
    logic [HOUR_W-1:0]    sb_h_inc;
    logic                 sb_done;
    // UV run count chain.
    logic [TICK_W-1:0]    run_t_inc;
    logic                 run_t_wrap;
    logic [RUN_MIN_W-1:0] run_m_inc;
    logic                 run_done;
    // Move timer.
    logic [TICK_W-1:0]    mt_inc;
    logic                 mt_expired;

    logic abort;
    logic paused;
    logic blocked;
    logic [STEP_W-1:0] skip_step;
    logic [POS_W-1:0]  target_pos;

    always_comb
    begin
        sb_t_inc  = sb_ticks_reg + TICK_W'(1);
        sb_t_wrap = (sb_t_inc >= cfg.ticks_per_minute);
        sb_m_inc  = sb_t_wrap ? sb_minutes_reg + SB_MIN_W'(1) : sb_minutes_reg;
        sb_m_wrap = (sb_m_inc >= MINUTES_PER_HOUR);
        sb_h_inc  = sb_m_wrap ? sb_hours_reg + HOUR_W'(1) : sb_hours_reg;
        sb_done   = (sb_h_inc >= cfg.standby_hours);

        run_t_inc  = run_ticks_reg + TICK_W'(1);
        run_t_wrap = (run_t_inc >= cfg.ticks_per_minute);
        run_m_inc  = run_t_wrap ? run_minutes_reg + RUN_MIN_W'(1) : run_minutes_reg;
        run_done   = (run_m_inc >= cfg.run_minutes);

        mt_inc     = move_timer_reg + TICK_W'(1);
        mt_expired = (mt_inc >= cfg.tray_timeout_ticks);
    end

    always_comb
    begin
        abort = req.ice_making_on | req.ice_init_active | req.ice_cycle_busy
              | req.other_process_active | ~req.tank_present;
        paused = req.tank_open_pause | req.extract_pause;
        blocked = (step_reg == STEP_UP_CMD) ? req.motor_down_busy : req.motor_up_busy;
        target_pos = (step_reg == STEP_UP_WAIT) ? POS_MAKING : POS_THROW;
        if (step_reg == STEP_DOWN_CMD)
        begin
            skip_step = STEP_RUN_A;
        end
        else if (step_reg == STEP_UP_CMD)
        begin
            skip_step = STEP_RUN_B;
        end
        else
        begin
            skip_step = STEP_RESTART;
        end
    end

    always_comb
    begin
        step_next        = step_reg;
        move_timer_next  = move_timer_reg;
        uv_active_next   = uv_active_reg;
        sb_ticks_next    = sb_ticks_reg;
        sb_minutes_next  = sb_minutes_reg;
        sb_hours_next    = sb_hours_reg;
        run_ticks_next   = run_ticks_reg;
        run_minutes_next = run_minutes_reg;
        rsp              = '0;

        if (abort)
        begin
            // A tray left up during the second half gets sent back down.
            if (step_reg >= STEP_UP_CMD && step_reg <= STEP_HOME_CMD && req.system_ok &&
                !req.motor_up_busy && req.tray_position != POS_THROW)
            begin
                rsp.tray_down_pulse = 1'b1;
            end
            sb_ticks_next    = '0;
            sb_minutes_next  = '0;
            sb_hours_next    = '0;
            run_ticks_next   = '0;
            run_minutes_next = '0;
            step_next        = STEP_STANDBY_A;
            uv_active_next   = 1'b0;
        end
        else
        begin
            unique case (step_reg)
                STEP_STANDBY_A, STEP_STANDBY_B:
                begin
                    if (sb_done)
                    begin
                        if (step_reg == STEP_STANDBY_A)
                        begin
                            move_timer_next = '0;
                        end
                        step_next        = step_reg + STEP_W'(1);
                        uv_active_next   = 1'b1;
                        sb_ticks_next    = '0;
                        sb_minutes_next  = '0;
                        sb_hours_next    = '0;
                        run_ticks_next   = '0;
                        run_minutes_next = '0;
                    end
                    else
                    begin
                        sb_ticks_next   = sb_t_wrap ? '0 : sb_t_inc;
                        sb_minutes_next = sb_m_wrap ? '0 : sb_m_inc;
                        sb_hours_next   = sb_h_inc;
                    end
                end
                STEP_DOWN_CMD, STEP_UP_CMD, STEP_HOME_CMD:
                begin
                    if (req.system_ok)
                    begin
                        if (!blocked)
                        begin
                            if (step_reg == STEP_UP_CMD)
                            begin
                                rsp.tray_up_pulse = 1'b1;
                            end
                            else
                            begin
                                rsp.tray_down_pulse = 1'b1;
                            end
                            move_timer_next = '0;
                            step_next       = step_reg + STEP_W'(1);
                        end
                        else
                        begin
                            move_timer_next = mt_expired ? '0 : mt_inc;
                            if (mt_expired)
                            begin
                                step_next = skip_step;
                            end
                        end
                    end
                    else
                    begin
                        move_timer_next = '0;
                        step_next       = skip_step;
                    end
                end
                STEP_DOWN_WAIT, STEP_UP_WAIT, STEP_HOME_WAIT:
                begin
                    if (req.tray_position == target_pos)
                    begin
                        move_timer_next = '0;
                        step_next       = step_reg + STEP_W'(1);
                    end
                    else
                    begin
                        move_timer_next = mt_expired ? '0 : mt_inc;
                        if (mt_expired)
                        begin
                            step_next = step_reg + STEP_W'(1);
                        end
                    end
                end
                STEP_RUN_A, STEP_RUN_B:
                begin
                    if (uv_active_reg)
                    begin
                        if (!paused)
                        begin
                            rsp.uv_on = 1'b1;
                            if (run_done)
                            begin
                                uv_active_next   = 1'b0;
                                sb_ticks_next    = '0;
                                sb_minutes_next  = '0;
                                sb_hours_next    = '0;
                                run_ticks_next   = '0;
                                run_minutes_next = '0;
                            end
                            else
                            begin
                                run_ticks_next   = run_t_wrap ? '0 : run_t_inc;
                                run_minutes_next = run_m_inc;
                            end
                        end
                    end
                    else
                    begin
                        move_timer_next = '0;
                        step_next       = step_reg + STEP_W'(1);
                    end
                end
                STEP_RESTART:
                begin
                    move_timer_next  = '0;
                    step_next        = STEP_STANDBY_A;
                    sb_ticks_next    = '0;
                    sb_minutes_next  = '0;
                    sb_hours_next    = '0;
                    run_ticks_next   = '0;
                    run_minutes_next = '0;
                end
                default:
                begin
                    move_timer_next = '0;
                    step_next       = STEP_STANDBY_A;
                end
            endcase
        end
        rsp.seq_step = step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= STEP_STANDBY_A;
            move_timer_reg  <= '0;
            uv_active_reg   <= 1'b0;
            sb_ticks_reg    <= '0;
            sb_minutes_reg  <= '0;
            sb_hours_reg    <= '0;
            run_ticks_reg   <= '0;
            run_minutes_reg <= '0;
        end
        else if (accept)
        begin
            step_reg        <= step_next;
            move_timer_reg  <= move_timer_next;
            uv_active_reg   <= uv_active_next;
            sb_ticks_reg    <= sb_ticks_next;
            sb_minutes_reg  <= sb_minutes_next;
            sb_hours_reg    <= sb_hours_next;
            run_ticks_reg   <= run_ticks_next;
            run_minutes_reg <= run_minutes_next;
        end
    end

endmodule

`default_nettype wire

[src/uv_tray_sterilize_sequencer_top.sv]
// Top level of the UV tray sterilize sequencer: channels, configuration and result register.
//
// The block takes one request per 100 ms appliance tick on the req channel. Each
// request carries the appliance status flags, the tray motor busy flags, the tray
// position and the two UV pause flags. For every accepted request exactly one
// result leaves on the rsp channel: the UV drive, the one-tick tray down and up
// commands, and the sequence step after that tick.
// The result is registered: a request accepted at a clock edge shows its result on
// rsp from that edge on. One request enters per cycle while the receiver takes
// each result; the compare and increment logic in front of the result register
// settles the whole sequence step; state updates at the edge accepting the request.
// The cfg channel writes the four timing registers (standby hours, run minutes,
// tray timeout ticks, ticks per minute) by index; it is always ready. Write them
// only while no result is outstanding.
// Reset puts the sequence at step 0 with all counters clear, empties the result
// register and loads the default register values (10 hours, 120 minutes, 600
// ticks, 600 ticks). When the receiver stalls, the result is held in its register
// and req.ready stays high only if that result leaves in the same cycle, so a new
// request can still enter while the previous result is being taken.
`default_nettype none

module uv_tray_sterilize_sequencer_top (
    input  logic clk,
    input  logic rst_n,
    uvts_req_if.sink   req,
    uvts_rsp_if.source rsp,
    uvts_cfg_if.sink   cfg
);
    import uvts_pkg::*;

    cfg_t cfg_reg;
    req_t req_item;
    rsp_t rsp_next;
    rsp_t rsp_reg;
    logic rsp_valid_reg;
    logic accept;

    // Configuration writes land directly; each register keeps only its own width.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.standby_hours      <= RST_STANDBY_HOURS;
            cfg_reg.run_minutes        <= RST_RUN_MINUTES;
            cfg_reg.tray_timeout_ticks <= RST_TRAY_TIMEOUT;
            cfg_reg.ticks_per_minute   <= RST_TICKS_PER_MIN;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_STANDBY_HOURS: cfg_reg.standby_hours      <= cfg.data[HOUR_W-1:0];
                CFG_RUN_MINUTES:   cfg_reg.run_minutes        <= cfg.data[RUN_MIN_W-1:0];
                CFG_TRAY_TIMEOUT:  cfg_reg.tray_timeout_ticks <= cfg.data[TICK_W-1:0];
                CFG_TICKS_PER_MIN: cfg_reg.ticks_per_minute   <= cfg.data[TICK_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // A request enters whenever the result register is empty or is emptied now.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        req_item.ice_making_on        = req.ice_making_on;
        req_item.ice_init_active      = req.ice_init_active;
        req_item.ice_cycle_busy       = req.ice_cycle_busy;
        req_item.other_process_active = req.other_process_active;
        req_item.tank_present         = req.tank_present;
        req_item.system_ok            = req.system_ok;
        req_item.motor_up_busy        = req.motor_up_busy;
        req_item.motor_down_busy      = req.motor_down_busy;
        req_item.tray_position        = req.tray_position;
        req_item.tank_open_pause      = req.tank_open_pause;
        req_item.extract_pause        = req.extract_pause;
    end

    uvts_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req_item),
        .cfg    (cfg_reg),
        .rsp    (rsp_next)
    );

    // Result register: valid is control state, the payload loads with each request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.uv_on           = rsp_reg.uv_on;
    assign rsp.tray_down_pulse = rsp_reg.tray_down_pulse;
    assign rsp.tray_up_pulse   = rsp_reg.tray_up_pulse;
    assign rsp.seq_step        = rsp_reg.seq_step;

endmodule

`default_nettype wire

[src/uvts_checker.sv]
// Port-level checker of the UV tray sterilize sequencer and its bind to the top level.
`default_nettype none

module uvts_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        uv_on,
    input logic                        tray_down_pulse,
    input logic                        tray_up_pulse,
    input logic [uvts_pkg::STEP_W-1:0] seq_step
);
    import uvts_pkg::*;

    // A result never commands the tray both ways at once.
    a_one_tray_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(tray_down_pulse && tray_up_pulse))
        else $error("tray up and down commanded together");

    // UV is driven only while the sequence sits in a run step.
    a_uv_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && uv_on) |-> (seq_step == STEP_RUN_A || seq_step == STEP_RUN_B))
        else $error("UV on outside a run step");

    // An up command always moves the sequence into the wait for the making position.
    a_up_step: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && tray_up_pulse) |-> (seq_step == STEP_UP_WAIT))
        else $error("tray up command with wrong step");

    // A down command either starts a throw wait or comes from an abort back to standby.
    a_down_step: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && tray_down_pulse) |->
            (seq_step == STEP_DOWN_WAIT || seq_step == STEP_HOME_WAIT ||
             seq_step == STEP_STANDBY_A))
        else $error("tray down command with wrong step");

    // A stalled result is not dropped.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("stalled result dropped");

endmodule

bind uv_tray_sterilize_sequencer_top uvts_checker u_uvts_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .uv_on           (rsp.uv_on),
    .tray_down_pulse (rsp.tray_down_pulse),
    .tray_up_pulse   (rsp.tray_up_pulse),
    .seq_step        (rsp.seq_step)
);

`default_nettype wire

[bench/uvts_tb_pkg.sv]
// Scoreboard class that tracks the sterilize sequence and checks each result of the sequencer.
`timescale 1ns / 1ps

package uvts_tb_pkg;

    import uvts_pkg::*;

    localparam int MAX_REPORTS = 10;

    class sequencer_scoreboard;

        // Timing registers as last written.
        logic [HOUR_W-1:0]    hours_limit;
        logic [RUN_MIN_W-1:0] run_limit;
        logic [TICK_W-1:0]    move_limit;
        logic [TICK_W-1:0]    minute_ticks;

        // Sequence state.
        logic [STEP_W-1:0]    step;
        logic [TICK_W-1:0]    move_count;
        logic                 uv_armed;
        logic [TICK_W-1:0]    sb_ticks;
        logic [SB_MIN_W-1:0]  sb_minutes;
        logic [HOUR_W-1:0]    sb_hours;
        logic [TICK_W-1:0]    run_ticks;
        logic [RUN_MIN_W-1:0] run_minutes_done;

        rsp_t outputs_due[$];
        int   fail_count;

        function new();
            hours_limit  = RST_STANDBY_HOURS;
            run_limit    = RST_RUN_MINUTES;
            move_limit   = RST_TRAY_TIMEOUT;
            minute_ticks = RST_TICKS_PER_MIN;
            step         = STEP_STANDBY_A;
            move_count   = '0;
            uv_armed     = 1'b0;
            clear_counters();
            fail_count   = 0;
        endfunction

        function int pending();
            return outputs_due.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_STANDBY_HOURS: hours_limit  = data[HOUR_W-1:0];
                CFG_RUN_MINUTES:   run_limit    = data[RUN_MIN_W-1:0];
                CFG_TRAY_TIMEOUT:  move_limit   = data[TICK_W-1:0];
                CFG_TICKS_PER_MIN: minute_ticks = data[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void clear_counters();
            sb_ticks         = '0;
            sb_minutes       = '0;
            sb_hours         = '0;
            run_ticks        = '0;
            run_minutes_done = '0;
        endfunction

        // Counts one tick of a tray move; true when the move has run out of time.
        function bit move_expired();
            move_count = move_count + 1'b1;
            if (move_count >= move_limit) begin
                move_count = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Applies one accepted request to the sequence and queues the result it should give.
        function void advance_sequence(req_t r);
            rsp_t              o;
            logic              paused;
            logic              blocked;
            logic [POS_W-1:0]  target;
            logic [STEP_W-1:0] skip;
            o      = '0;
            paused = r.tank_open_pause | r.extract_pause;
            if (r.ice_making_on || r.ice_init_active || r.ice_cycle_busy ||
                r.other_process_active || !r.tank_present) begin
                // Leaving the sequence with the tray up: send it back toward throw.
                if (step >= STEP_UP_CMD && step <= STEP_HOME_CMD && r.system_ok &&
                    !r.motor_up_busy && r.tray_position != POS_THROW)
                    o.tray_down_pulse = 1'b1;
                clear_counters();
                step     = STEP_STANDBY_A;
                uv_armed = 1'b0;
            end else begin
                case (step)
                    STEP_STANDBY_A, STEP_STANDBY_B:
                    begin
                        sb_ticks = sb_ticks + 1'b1;
                        if (sb_ticks >= minute_ticks) begin
                            sb_ticks   = '0;
                            sb_minutes = sb_minutes + 1'b1;
                        end
                        if (sb_minutes >= MINUTES_PER_HOUR) begin
                            sb_minutes = '0;
                            sb_hours   = sb_hours + 1'b1;
                        end
                        if (sb_hours >= hours_limit) begin
                            clear_counters();
                            if (step == STEP_STANDBY_A)
                                move_count = '0;
                            step     = step + 1'b1;
                            uv_armed = 1'b1;
                        end
                    end
                    STEP_DOWN_CMD, STEP_UP_CMD, STEP_HOME_CMD:
                    begin
                        blocked = (step == STEP_UP_CMD) ? r.motor_down_busy : r.motor_up_busy;
                        skip    = (step == STEP_DOWN_CMD) ? STEP_RUN_A :
                                  (step == STEP_UP_CMD)   ? STEP_RUN_B : STEP_RESTART;
                        if (!r.system_ok) begin
                            move_count = '0;
                            step       = skip;
                        end else if (!blocked) begin
                            if (step == STEP_UP_CMD)
                                o.tray_up_pulse = 1'b1;
                            else
                                o.tray_down_pulse = 1'b1;
                            move_count = '0;
                            step       = step + 1'b1;
                        end else if (move_expired()) begin
                            step = skip;
                        end
                    end
                    STEP_DOWN_WAIT, STEP_UP_WAIT, STEP_HOME_WAIT:
                    begin
                        target = (step == STEP_UP_WAIT) ? POS_MAKING : POS_THROW;
                        if (r.tray_position == target) begin
                            move_count = '0;
                            step       = step + 1'b1;
                        end else if (move_expired()) begin
                            step = step + 1'b1;
                        end
                    end
                    STEP_RUN_A, STEP_RUN_B:
                    begin
                        if (uv_armed) begin
                            if (!paused) begin
                                o.uv_on   = 1'b1;
                                run_ticks = run_ticks + 1'b1;
                                if (run_ticks >= minute_ticks) begin
                                    run_ticks        = '0;
                                    run_minutes_done = run_minutes_done + 1'b1;
                                end
                                if (run_minutes_done >= run_limit) begin
                                    uv_armed = 1'b0;
                                    clear_counters();
                                end
                            end
                        end else begin
                            move_count = '0;
                            step       = step + 1'b1;
                        end
                    end
                    STEP_RESTART:
                    begin
                        move_count = '0;
                        step       = STEP_STANDBY_A;
                        clear_counters();
                    end
                    default:
                    begin
                        move_count = '0;
                        step       = STEP_STANDBY_A;
                    end
                endcase
            end
            o.seq_step = step;
            outputs_due.push_back(o);
        endfunction

        function void check_outputs(rsp_t got);
            rsp_t want;
            if (outputs_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: uv=%0d down=%0d up=%0d step=%0d",
                             got.uv_on, got.tray_down_pulse, got.tray_up_pulse, got.seq_step);
                return;
            end
            want = outputs_due.pop_front();
            if (got.uv_on !== want.uv_on || got.tray_down_pulse !== want.tray_down_pulse ||
                got.tray_up_pulse !== want.tray_up_pulse || got.seq_step !== want.seq_step) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("mismatch: expected uv=%0d down=%0d up=%0d step=%0d, got uv=%0d down=%0d up=%0d step=%0d",
                             want.uv_on, want.tray_down_pulse, want.tray_up_pulse,
                             want.seq_step, got.uv_on, got.tray_down_pulse,
                             got.tray_up_pulse, got.seq_step);
            end
        endfunction

    endclass

endpackage

[bench/tb_uv_tray_sterilize_sequencer_top.sv]
// Testbench top for the UV tray sterilize sequencer: stimulus, handshakes and the final verdict.
`timescale 1ns / 1ps

module tb_uv_tray_sterilize_sequencer_top;

    import uvts_pkg::*;
    import uvts_tb_pkg::*;

    // A tick with every abort condition clear, the system healthy, the motors idle
    // and the tray between positions. Directed requests start from it.
    localparam req_t STEADY_TICK = '{
        ice_making_on:        1'b0,
        ice_init_active:      1'b0,
        ice_cycle_busy:       1'b0,
        other_process_active: 1'b0,
        tank_present:         1'b1,
        system_ok:            1'b1,
        motor_up_busy:        1'b0,
        motor_down_busy:      1'b0,
        tray_position:        2'd0,
        tank_open_pause:      1'b0,
        extract_pause:        1'b0
    };

    // Length of the deliberate receiver hold-off, in cycles.
    localparam int HOLD_OFF_CYCLES = 80;

    logic clk;
    logic rst_n;

    uvts_req_if req_ch ();
    uvts_rsp_if rsp_ch ();
    uvts_cfg_if cfg_ch ();

    uv_tray_sterilize_sequencer_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    sequencer_scoreboard sb;

    // Idle rates of both sides, in percent of cycles. The main flow changes them
    // between phases.
    int src_idle_pct;
    int snk_idle_pct;

    // Set once by the main flow; the result side then holds off for a long
    // stretch while requests keep coming, so the block fills and stalls its input.
    bit stall_armed;
    bit stall_done;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Copies the fields of one tick onto the request channel.
    task automatic put_fields(input req_t r);
        req_ch.ice_making_on        <= r.ice_making_on;
        req_ch.ice_init_active      <= r.ice_init_active;
        req_ch.ice_cycle_busy       <= r.ice_cycle_busy;
        req_ch.other_process_active <= r.other_process_active;
        req_ch.tank_present         <= r.tank_present;
        req_ch.system_ok            <= r.system_ok;
        req_ch.motor_up_busy        <= r.motor_up_busy;
        req_ch.motor_down_busy      <= r.motor_down_busy;
        req_ch.tray_position        <= r.tray_position;
        req_ch.tank_open_pause      <= r.tank_open_pause;
        req_ch.extract_pause        <= r.extract_pause;
    endtask

    // Offers one request, with random idle cycles in front of it, and waits until
    // the block takes it. It is entered and left at a falling edge, so valid gets
    // at most one assignment in any time step.
    task automatic send_tick(input req_t r);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        put_fields(r);
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        sb.advance_sequence(r);
        @(negedge clk);
    endtask

    // Stops offering requests and waits until every result that is owed has left.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Writes all four timing registers, one request on the configuration channel each.
    task automatic load_config(input logic [HOUR_W-1:0] hrs, input logic [RUN_MIN_W-1:0] mins,
                               input logic [TICK_W-1:0] tmo, input logic [TICK_W-1:0] tpm);
        logic [CFG_IDX_W-1:0]  idx  [4];
        logic [CFG_DATA_W-1:0] vals [4];
        idx  = '{CFG_STANDBY_HOURS, CFG_RUN_MINUTES, CFG_TRAY_TIMEOUT, CFG_TICKS_PER_MIN};
        vals = '{CFG_DATA_W'(hrs), CFG_DATA_W'(mins), tmo, tpm};
        for (int i = 0; i < 4; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (cfg_ch.ready !== 1'b1)
                @(posedge clk);
            sb.write_reg(idx[i], vals[i]);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // A mostly well-formed tick: abort conditions are rare so that the sequence
    // gets through its long standby count, motors and pauses come and go, and the
    // tray position takes every code including the unused one. A small share of
    // ticks is pure noise.
    function automatic req_t random_tick();
        req_t r;
        int   roll;
        r                 = STEADY_TICK;
        r.system_ok       = ($urandom_range(0, 99) < 92);
        r.motor_up_busy   = ($urandom_range(0, 99) < 30);
        r.motor_down_busy = ($urandom_range(0, 99) < 30);
        r.tray_position   = POS_W'($urandom_range(0, 3));
        r.tank_open_pause = ($urandom_range(0, 99) < 20);
        r.extract_pause   = ($urandom_range(0, 99) < 20);
        roll = $urandom_range(0, 399);
        case (roll)
            0: r.ice_making_on        = 1'b1;
            1: r.ice_init_active      = 1'b1;
            2: r.ice_cycle_busy       = 1'b1;
            3: r.other_process_active = 1'b1;
            4: r.tank_present         = 1'b0;
            5: r = req_t'($urandom);
            default: ;
        endcase
        return r;
    endfunction

    // Directed walk through the sequence. The first two requests abort from the
    // reset settings; then fast timing is loaded so that the standby count ends on
    // its first tick and each UV run lasts a single counted tick. The walk covers a
    // blocked move that times out, both pause flags, an unused tray code, every
    // tray pulse, the restart step, an unhealthy system during a tray wait, the
    // tray-down pulse on an abort while the tray is up, and every abort flag.
    task automatic run_directed();
        req_t r;
        for (int i = 0; i < 27; i++) begin
            if (i == 2) begin
                drain_results();
                load_config(4'd0, 8'd1, 16'd2, 16'd0);
            end
            r = STEADY_TICK;
            case (i)
                0:  r.ice_making_on        = 1'b1;
                1:  r.tank_present         = 1'b0;
                3,
                4:  r.motor_up_busy        = 1'b1;
                5:  r.tank_open_pause      = 1'b1;
                10: r.motor_down_busy      = 1'b1;
                12: r.tray_position        = 2'd3;
                13: r.tray_position        = POS_MAKING;
                14: r.extract_pause        = 1'b1;
                18: r.tray_position        = POS_THROW;
                21: r.system_ok            = 1'b0;
                25: r.ice_init_active      = 1'b1;
                26: r.ice_cycle_busy       = 1'b1;
                default: ;
            endcase
            send_tick(r);
        end
        // One more abort source, hit from the standby step.
        r = STEADY_TICK;
        r.other_process_active = 1'b1;
        send_tick(r);
    endtask

    // One random phase: settle, load a timing setting, then stream random ticks.
    // The sequence state carries over from the phase before, so lowering a
    // register can catch a counter already past the new value.
    task automatic run_phase(input logic [HOUR_W-1:0] hrs, input logic [RUN_MIN_W-1:0] mins,
                             input logic [TICK_W-1:0] tmo, input logic [TICK_W-1:0] tpm,
                             input int ticks);
        drain_results();
        load_config(hrs, mins, tmo, tpm);
        repeat (ticks)
            send_tick(random_tick());
    endtask

    // Result side: ready changes at the falling edge. The long hold-off is counted
    // here, in cycles, once the main flow arms it.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (stall_armed && !stall_done) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                stall_done = 1'b1;
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Every result taken at a rising edge is checked against the oldest one owed.
    initial begin
        rsp_t got;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                got = {rsp_ch.uv_on, rsp_ch.tray_down_pulse, rsp_ch.tray_up_pulse,
                       rsp_ch.seq_step};
                sb.check_outputs(got);
            end
        end
    end

    // Main flow: reset, directed walk, then random phases under three idle
    // patterns and several timing settings, the extremes among them.
    initial begin
        sb           = new();
        stall_armed  = 1'b0;
        stall_done   = 1'b0;
        src_idle_pct = 38;
        snk_idle_pct = 54;
        req_ch.valid <= 1'b0;
        put_fields(STEADY_TICK);
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_STANDBY_HOURS;
        cfg_ch.data  <= '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_phase(4'd1, 8'd2, 16'd3, 16'd1, 130);
        run_phase(4'd0, 8'd255, 16'd65535, 16'd0, 130);

        src_idle_pct = 54;
        snk_idle_pct = 38;
        run_phase(4'd15, 8'd255, 16'd65535, 16'd65535, 40);
        run_phase(4'd0, 8'd3, 16'd2, 16'd2, 130);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_phase(4'd1, 8'd1, 16'd1, 16'd0, 130);

        // The hold-off starts only once the requests of this phase are flowing.
        drain_results();
        load_config(4'd0, 8'd1, 16'd4, 16'd1);
        stall_armed = 1'b1;
        repeat (130)
            send_tick(random_tick());

        drain_results();
        repeat (10) @(negedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Guard against a hung handshake: far longer than the slowest correct run.
    initial begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
